FILE: src/stt_pkg.sv
// ============================================================================
// stt_pkg: shared types and constants of the software timer table
// Opcodes, result kinds, entry status codes, register indexes and the
// command word passed from the front end to the back end.
// ============================================================================
`default_nettype none
package stt_pkg;

   localparam int NUM_TIMERS_DEF = 32;
   localparam int IDX_W          = 6;
   localparam int TMO_W          = 32;
   localparam int QUE_W          = 4;
   localparam int DAT_W          = 8;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_ALLOC    = 3'd1,
      OP_FREE     = 3'd2,
      OP_INIT     = 3'd3,
      OP_SETTIME  = 3'd4
   } op_type;

   localparam logic [1:0] KIND_REPLY  = 2'd0;
   localparam logic [1:0] KIND_EXPIRY = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_ALLOC = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   localparam logic REG_TASK_EN  = 1'b0;
   localparam logic REG_TASK_IDX = 1'b1;

   // command word from front to back; op_ok is set for a known opcode
   typedef struct packed {
      logic [2:0]       op;
      logic             op_ok;
      logic [IDX_W-1:0] idx;
      logic [TMO_W-1:0] tmo;
      logic [QUE_W-1:0] que;
      logic [DAT_W-1:0] dat;
   } cmd_type;

endpackage
`default_nettype wire

FILE: src/software_timer_table.sv
// ============================================================================
// software_timer_table: table of one-shot timers with expiry events
// Commands allocate, free, init and start timers; a tick counts down every
// running timer and reports each expiry, then an end-of-tick word.
// ============================================================================
//  channel  | handshake          | payload
//  req      | push / full        | opcode, index, timeout, queue, data
//  rsp      | pop / empty        | kind, index, ok, queue, byte, switch, count, last
//  csr      | csr_valid/ready    | csr_index, csr_wdata
//
// Free, init, settime and unknown opcodes are answered from the idle state.
// Allocate steps from entry 0 to the first free entry, or past the last one.
// A tick walks every entry, one per cycle while no result word is held.
// Reset is synchronous; all timers come out free and the tick count zero.
// A held result word stalls the walk; the two-word front queue keeps taking
// requests meanwhile, until it is full.
`default_nettype none
module software_timer_table import stt_pkg::*; #(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [2:0]       req_opcode,
   input  wire logic [IDX_W-1:0] req_timer_index,
   input  wire logic [TMO_W-1:0] req_timeout_ticks,
   input  wire logic [QUE_W-1:0] req_dest_queue,
   input  wire logic [DAT_W-1:0] req_event_data,
   output logic                  empty,
   input  wire logic             pop,
   output logic [1:0]            rsp_kind,
   output logic [IDX_W-1:0]      rsp_entry_index,
   output logic                  rsp_ok,
   output logic [QUE_W-1:0]      rsp_event_queue,
   output logic [DAT_W-1:0]      rsp_event_byte,
   output logic                  rsp_switch_request,
   output logic [TMO_W-1:0]      rsp_tick_count,
   output logic                  rsp_last,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [IDX_W-1:0] csr_wdata
);

   logic             cmd_valid, cmd_take;
   cmd_type          cmd;
   logic             task_en_ff;
   logic [IDX_W-1:0] task_idx_ff;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         task_en_ff  <= 1'b0;
         task_idx_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == REG_TASK_EN) task_en_ff <= csr_wdata[0];
         else task_idx_ff <= csr_wdata;
      end
   end

   stt_front u_front (
      .clock, .reset, .push, .full,
      .req_opcode, .req_timer_index, .req_timeout_ticks, .req_dest_queue,
      .req_event_data, .cmd_valid, .cmd_take, .cmd
   );

   stt_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd,
      .task_en(task_en_ff), .task_idx(task_idx_ff),
      .empty, .pop, .rsp_kind, .rsp_entry_index, .rsp_ok, .rsp_event_queue,
      .rsp_event_byte, .rsp_switch_request, .rsp_tick_count, .rsp_last
   );

`ifndef SYNTH
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("command taken from empty queue");
   a_switch_tick: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_switch_request) |-> rsp_kind == KIND_TICK)
      else $error("switch request outside end of tick");
   a_tick_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == KIND_TICK) |-> rsp_last)
      else $error("end of tick not last");
`endif

endmodule
`default_nettype wire

FILE: src/stt_front.sv
// ============================================================================
// stt_front: command intake
// Accepts request words, classifies the opcode and holds them in a
// two-entry queue for the back end.
// ============================================================================
`default_nettype none
module stt_front import stt_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [2:0]       req_opcode,
   input  wire logic [IDX_W-1:0] req_timer_index,
   input  wire logic [TMO_W-1:0] req_timeout_ticks,
   input  wire logic [QUE_W-1:0] req_dest_queue,
   input  wire logic [DAT_W-1:0] req_event_data,
   output logic                  cmd_valid,
   input  wire logic             cmd_take,
   output cmd_type               cmd
);

   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   cmd_type    new_cmd;
   logic       do_push, do_pop;

   // classify the incoming word
   always_comb begin
      new_cmd.op    = req_opcode;
      new_cmd.op_ok = (req_opcode inside {OP_TICK, OP_ALLOC, OP_FREE, OP_INIT,
                                          OP_SETTIME});
      new_cmd.idx   = req_timer_index;
      new_cmd.tmo   = (req_timeout_ticks == '0) ? TMO_W'(1) : req_timeout_ticks;
      new_cmd.que   = req_dest_queue;
      new_cmd.dat   = req_event_data;
   end

   assign full      = cnt_ff[1];
   assign do_push   = push && !full;
   assign cmd_valid = cnt_ff != 2'd0;
   assign do_pop    = cmd_take && cmd_valid;
   assign cmd       = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
      rd_in  = rd_ff ^ do_pop;
      wr_in  = wr_ff ^ do_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ff] <= new_cmd;
   end

endmodule
`default_nettype wire

FILE: src/stt_back.sv
// ============================================================================
// stt_back: timer table engine
// Executes one command at a time; results go to a one-word output register.
// A tick (while no result is held) or an allocate walks one entry per cycle.
// ============================================================================
`default_nettype none
module stt_back import stt_pkg::*; #(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   output logic                  cmd_take,
   input  cmd_type               cmd,
   input  wire logic             task_en,
   input  wire logic [IDX_W-1:0] task_idx,
   output logic                  empty,
   input  wire logic             pop,
   output logic [1:0]            rsp_kind,
   output logic [IDX_W-1:0]      rsp_entry_index,
   output logic                  rsp_ok,
   output logic [QUE_W-1:0]      rsp_event_queue,
   output logic [DAT_W-1:0]      rsp_event_byte,
   output logic                  rsp_switch_request,
   output logic [TMO_W-1:0]      rsp_tick_count,
   output logic                  rsp_last
);

   localparam int PW = $clog2(NUM_TIMERS + 1);
   localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_WALK  = 4'b0100,
      S_ALLOC = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       status_ff [NUM_TIMERS];
   logic [TMO_W-1:0] remain_mem [NUM_TIMERS];
   logic [QUE_W-1:0] que_mem [NUM_TIMERS];
   logic [DAT_W-1:0] dat_mem [NUM_TIMERS];
   logic [TMO_W-1:0] rd_remain_ff;
   logic [QUE_W-1:0] rd_que_ff;
   logic [DAT_W-1:0] rd_dat_ff;
   logic [PW-1:0]    ptr_ff, ptr_in;
   logic [TMO_W-1:0] ticks_ff;
   logic             sw_ff, sw_in;
   logic             ovalid_ff;
   logic             out_free, hit, expire, in_table, cur_run;
   logic [AW-1:0]    ptr_a, rd_a, cmd_a;
   logic [TMO_W-1:0] dec;

   assign out_free = !ovalid_ff || pop;
   assign empty    = !ovalid_ff;
   assign ptr_a    = ptr_ff[AW-1:0];
   assign cmd_a    = cmd.idx[AW-1:0];
   assign in_table = 32'(cmd.idx) < NUM_TIMERS;
   // read pointer runs one ahead of the walk pointer
   assign rd_a     = (state_ff == S_WALK) ? AW'(ptr_ff + PW'(1)) : ptr_a;
   // the end-of-tick step past the last entry touches no entry
   assign cur_run  = (ptr_ff != PW'(NUM_TIMERS)) && status_ff[ptr_a] == ST_RUN;
   assign dec      = rd_remain_ff - TMO_W'(1);
   assign expire   = (state_ff == S_WALK) && out_free && cur_run && dec == '0;
   assign hit      = task_en && task_idx == IDX_W'(ptr_ff);

   // control
   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      sw_in    = sw_ff;
      cmd_take = 1'b0;
      case (state_ff)
         S_IDLE: begin
            ptr_in = '0;
            sw_in  = 1'b0;
            if (cmd_valid && out_free) begin
               if (cmd.op_ok && cmd.op == OP_TICK) state_in = S_READ;
               else if (cmd.op_ok && cmd.op == OP_ALLOC) state_in = S_ALLOC;
               else cmd_take = 1'b1;
            end
         end
         S_READ: state_in = S_WALK;
         S_WALK: begin
            if (out_free) begin
               if (expire && hit) sw_in = 1'b1;
               if (ptr_ff == PW'(NUM_TIMERS)) begin
                  cmd_take = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  ptr_in = ptr_ff + PW'(1);
               end
            end
         end
         S_ALLOC: begin
            if (ptr_ff == PW'(NUM_TIMERS) || status_ff[ptr_a] == ST_FREE) begin
               cmd_take = 1'b1;
               state_in = S_IDLE;
            end else begin
               ptr_in = ptr_ff + PW'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ptr_ff   <= '0;
         sw_ff    <= 1'b0;
         ticks_ff <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         sw_ff    <= sw_in;
         if (state_ff == S_IDLE && state_in == S_READ) ticks_ff <= ticks_ff + TMO_W'(1);
      end
   end

   // entry status flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) status_ff[i] <= ST_FREE;
      end else if (expire) begin
         status_ff[ptr_a] <= ST_ALLOC;
      end else if (state_ff == S_ALLOC && ptr_ff != PW'(NUM_TIMERS)
                   && status_ff[ptr_a] == ST_FREE) begin
         status_ff[ptr_a] <= ST_ALLOC;
      end else if (state_ff == S_IDLE && cmd_take && in_table && cmd.op_ok) begin
         if (cmd.op == OP_FREE) status_ff[cmd_a] <= ST_FREE;
         else if (cmd.op == OP_SETTIME) status_ff[cmd_a] <= ST_RUN;
      end
   end

   // entry memories: one write port, registered read at the read pointer
   always_ff @(posedge clock) begin
      if (state_ff == S_WALK && out_free && cur_run) begin
         remain_mem[ptr_a] <= dec;
      end else if (state_ff == S_IDLE && cmd_take && in_table && cmd.op_ok
                   && cmd.op == OP_SETTIME) begin
         remain_mem[cmd_a] <= cmd.tmo;
      end
      if (state_ff == S_IDLE && cmd_take && in_table && cmd.op_ok
          && cmd.op == OP_INIT) begin
         que_mem[cmd_a] <= cmd.que;
         dat_mem[cmd_a] <= cmd.dat;
      end
      if (state_ff == S_READ || (state_ff == S_WALK && out_free)) begin
         rd_remain_ff <= remain_mem[rd_a];
         rd_que_ff    <= que_mem[rd_a];
         rd_dat_ff    <= dat_mem[rd_a];
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (out_free) begin
         ovalid_ff <= 1'b0;
         if (expire) begin
            ovalid_ff          <= 1'b1;
            rsp_kind           <= KIND_EXPIRY;
            rsp_entry_index    <= IDX_W'(ptr_ff);
            rsp_ok             <= 1'b1;
            rsp_event_queue    <= rd_que_ff;
            rsp_event_byte     <= rd_dat_ff;
            rsp_switch_request <= 1'b0;
            rsp_tick_count     <= ticks_ff;
            rsp_last           <= 1'b0;
         end else if (cmd_take) begin
            ovalid_ff          <= 1'b1;
            rsp_event_queue    <= '0;
            rsp_event_byte     <= '0;
            rsp_last           <= 1'b1;
            if (state_ff == S_WALK) begin
               rsp_kind           <= KIND_TICK;
               rsp_entry_index    <= '0;
               rsp_ok             <= 1'b1;
               rsp_switch_request <= sw_ff;
               rsp_tick_count     <= ticks_ff;
            end else begin
               rsp_kind           <= KIND_REPLY;
               rsp_switch_request <= 1'b0;
               rsp_tick_count     <= '0;
               if (state_ff == S_ALLOC) begin
                  rsp_ok          <= ptr_ff != PW'(NUM_TIMERS);
                  rsp_entry_index <= (ptr_ff != PW'(NUM_TIMERS)) ? IDX_W'(ptr_ff) : '0;
               end else begin
                  rsp_ok          <= cmd.op_ok && in_table;
                  rsp_entry_index <= cmd.op_ok ? cmd.idx : '0;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

FILE: dv/software_timer_table_tb.sv
// ============================================================================
// software_timer_table_tb: self-checking bench for the timer table
// Drives a directed table of commands and ticks, then random phases under
// several task timer settings, with random gaps on both queue sides. Every
// result word is checked field by field against an in-bench table model.
// ============================================================================
`timescale 1ns / 1ps
module software_timer_table_tb;
   import stt_pkg::*;

   localparam int NT        = NUM_TIMERS_DEF;
   localparam int DRAIN_CYC = NT + 8;
   localparam int CYC_LIMIT = 2000000;
   localparam logic [2:0] OP_BAD5 = 3'd5;
   localparam logic [2:0] OP_BAD6 = 3'd6;
   localparam logic [2:0] OP_BAD7 = 3'd7;

   typedef struct packed {
      logic [1:0]       kind;
      logic [IDX_W-1:0] idx;
      logic             ok;
      logic [QUE_W-1:0] que;
      logic [DAT_W-1:0] byt;
      logic             sw;
      logic [TMO_W-1:0] cnt;
      logic             last;
   } rsp_word_t;

   typedef struct {
      logic [2:0]       op;
      logic [IDX_W-1:0] idx;
      logic [TMO_W-1:0] tmo;
      logic [QUE_W-1:0] que;
      logic [DAT_W-1:0] dat;
      bit               typed;
      rsp_word_t        reply;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [2:0]       req_opcode = '0;
   logic [IDX_W-1:0] req_timer_index = '0;
   logic [TMO_W-1:0] req_timeout_ticks = '0;
   logic [QUE_W-1:0] req_dest_queue = '0;
   logic [DAT_W-1:0] req_event_data = '0;
   logic empty;
   logic pop = 1'b0;
   logic [1:0]       rsp_kind;
   logic [IDX_W-1:0] rsp_entry_index;
   logic             rsp_ok;
   logic [QUE_W-1:0] rsp_event_queue;
   logic [DAT_W-1:0] rsp_event_byte;
   logic             rsp_switch_request;
   logic [TMO_W-1:0] rsp_tick_count;
   logic             rsp_last;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_index = 1'b0;
   logic [IDX_W-1:0] csr_wdata = '0;

   software_timer_table DUT (.*);

   always #6 clock = ~clock;

   // table model state
   logic [1:0]       tm_status [NT];
   logic [TMO_W-1:0] tm_remain [NT];
   logic [QUE_W-1:0] tm_queue [NT];
   logic [DAT_W-1:0] tm_byte [NT];
   bit               tm_inited [NT];
   logic [TMO_W-1:0] tm_ticks;
   logic             tm_task_en;
   logic [IDX_W-1:0] tm_task_idx;

   rsp_word_t pending_results [$];
   bit        typed_valid;
   rsp_word_t typed_reply;
   // typed reply that travels with the word on the request ports
   bit        cur_typed_valid;
   rsp_word_t cur_typed_reply;
   bit        no_idle;
   int        mismatches, words_seen, items_sent, expiries_seen, switches_seen;
   int        cycles;

   function automatic rsp_word_t mk(logic [1:0] k, logic [IDX_W-1:0] i, logic ok,
                                    logic [QUE_W-1:0] q, logic [DAT_W-1:0] b,
                                    logic sw, logic [TMO_W-1:0] c, logic l);
      rsp_word_t w;
      w = '{kind: k, idx: i, ok: ok, que: q, byt: b, sw: sw, cnt: c, last: l};
      return w;
   endfunction

   // work out every word one accepted request causes
   task automatic predict_table_step(logic [2:0] op, logic [IDX_W-1:0] idx,
                                     logic [TMO_W-1:0] tmo, logic [QUE_W-1:0] q,
                                     logic [DAT_W-1:0] d);
      bit sw;
      bit hit;
      bit in_tab;
      sw = 0;
      hit = 0;
      in_tab = 32'(idx) < NT;
      case (op)
         OP_TICK: begin
            tm_ticks = tm_ticks + 1;
            for (int i = 0; i < NT; i++) begin
               if (tm_status[i] == ST_RUN) begin
                  tm_remain[i] = tm_remain[i] - 1;
                  if (tm_remain[i] == 0) begin
                     tm_status[i] = ST_ALLOC;
                     pending_results.push_back(mk(KIND_EXPIRY, IDX_W'(i), 1'b1,
                                                  tm_queue[i], tm_byte[i], 1'b0,
                                                  tm_ticks, 1'b0));
                     if (tm_task_en && 32'(tm_task_idx) == i) sw = 1;
                  end
               end
            end
            pending_results.push_back(mk(KIND_TICK, 0, 1'b1, 0, 0, sw, tm_ticks, 1'b1));
         end
         OP_ALLOC: begin
            for (int i = 0; i < NT; i++) begin
               if (!hit && tm_status[i] == ST_FREE) begin
                  hit = 1;
                  tm_status[i] = ST_ALLOC;
                  pending_results.push_back(mk(KIND_REPLY, IDX_W'(i), 1'b1, 0, 0, 0, 0,
                                               1'b1));
               end
            end
            if (!hit) pending_results.push_back(mk(KIND_REPLY, 0, 1'b0, 0, 0, 0, 0, 1'b1));
         end
         OP_FREE, OP_INIT, OP_SETTIME: begin
            if (in_tab) begin
               if (op == OP_FREE) begin
                  tm_status[idx] = ST_FREE;
               end else if (op == OP_INIT) begin
                  tm_queue[idx] = q;
                  tm_byte[idx] = d;
                  tm_inited[idx] = 1;
               end else begin
                  tm_remain[idx] = (tmo == 0) ? 1 : tmo;
                  tm_status[idx] = ST_RUN;
               end
            end
            pending_results.push_back(mk(KIND_REPLY, idx, in_tab, 0, 0, 0, 0, 1'b1));
         end
         default: pending_results.push_back(mk(KIND_REPLY, 0, 1'b0, 0, 0, 0, 0, 1'b1));
      endcase
      // typed rows replace the lone reply word
      if (cur_typed_valid) pending_results[pending_results.size()-1] = cur_typed_reply;
   endtask

   // request side monitor
   always @(posedge clock) begin
      if (!reset && push && !full) begin
         predict_table_step(req_opcode, req_timer_index, req_timeout_ticks,
                            req_dest_queue, req_event_data);
         items_sent++;
      end
   end

   // result side checker
   always @(posedge clock) begin
      rsp_word_t got, want;
      if (!reset && pop && !empty) begin
         got = mk(rsp_kind, rsp_entry_index, rsp_ok, rsp_event_queue, rsp_event_byte,
                  rsp_switch_request, rsp_tick_count, rsp_last);
         words_seen++;
         if (got.kind == KIND_EXPIRY) expiries_seen++;
         if (got.sw) switches_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word mismatch at %0t\n  exp %p\n  got %p", $realtime, want, got);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYC_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 17);
   endfunction

   // pop side with random stalls
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
      end
   end

   task automatic send_word(logic [2:0] op, logic [IDX_W-1:0] idx, logic [TMO_W-1:0] tmo,
                            logic [QUE_W-1:0] q, logic [DAT_W-1:0] d);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_opcode <= op;
      req_timer_index <= idx;
      req_timeout_ticks <= tmo;
      req_dest_queue <= q;
      req_event_data <= d;
      cur_typed_valid <= typed_valid;
      cur_typed_reply <= typed_reply;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic write_reg(logic ridx, logic [IDX_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= ridx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (ridx == REG_TASK_EN) tm_task_en = val[0];
      else tm_task_idx = val;
      @(posedge clock);
   endtask

   // random request, biased toward well-formed use of inited entries
   task automatic send_random();
      int r;
      logic [2:0] op;
      logic [IDX_W-1:0] idx;
      logic [TMO_W-1:0] tmo;
      r = $urandom_range(0, 99);
      if (r < 25) op = OP_TICK;
      else if (r < 40) op = OP_ALLOC;
      else if (r < 52) op = OP_FREE;
      else if (r < 72) op = OP_INIT;
      else if (r < 95) op = OP_SETTIME;
      else op = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 99);
      if (r < 10) idx = IDX_W'($urandom_range(NT, 63));
      else if (r < 35) idx = tm_task_idx;
      else idx = IDX_W'($urandom_range(0, NT - 1));
      if (op == OP_SETTIME && 32'(idx) < NT && !tm_inited[idx]) op = OP_INIT;
      r = $urandom_range(0, 99);
      if (r < 70) tmo = $urandom_range(0, 6);
      else if (r < 92) tmo = $urandom_range(0, 40);
      else tmo = $urandom;
      send_word(op, idx, tmo, QUE_W'($urandom), DAT_W'($urandom));
   endtask

   stim_row_t rows [$];

   task automatic add_row(logic [2:0] op, logic [IDX_W-1:0] idx, logic [TMO_W-1:0] tmo,
                          logic [QUE_W-1:0] q, logic [DAT_W-1:0] d, bit typed,
                          rsp_word_t w);
      stim_row_t s;
      s = '{op: op, idx: idx, tmo: tmo, que: q, dat: d, typed: typed, reply: w};
      rows.push_back(s);
   endtask

   initial begin
      rsp_word_t nil;
      logic [IDX_W-1:0] task_ids [4];
      nil = '0;
      for (int i = 0; i < NT; i++) begin
         tm_status[i] = ST_FREE;
         tm_remain[i] = '0;
         tm_queue[i] = '0;
         tm_byte[i] = '0;
         tm_inited[i] = 0;
      end
      tm_ticks = '0;
      tm_task_en = 1'b0;
      tm_task_idx = '0;
      no_idle = 1;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: task timer on entry 1
      write_reg(REG_TASK_EN, 1);
      write_reg(REG_TASK_IDX, 1);
      add_row(OP_ALLOC, 0, 0, 0, 0, 1, mk(KIND_REPLY, 0, 1, 0, 0, 0, 0, 1));
      add_row(OP_ALLOC, 0, 0, 0, 0, 1, mk(KIND_REPLY, 1, 1, 0, 0, 0, 0, 1));
      add_row(OP_INIT, 0, 0, 4'hF, 8'hFF, 0, nil);
      add_row(OP_INIT, 1, 0, 4'h0, 8'h00, 0, nil);
      add_row(OP_INIT, 2, 0, 4'h5, 8'hA5, 0, nil);
      add_row(OP_SETTIME, 0, 0, 0, 0, 0, nil);             // zero timeout acts as one
      add_row(OP_SETTIME, 1, 3, 0, 0, 0, nil);
      add_row(OP_SETTIME, 2, 32'hFFFF_FFFF, 0, 0, 0, nil);
      add_row(OP_TICK, 0, 0, 0, 0, 0, nil);
      add_row(OP_TICK, 0, 0, 0, 0, 0, nil);
      add_row(OP_TICK, 0, 0, 0, 0, 0, nil);                // task timer fires
      add_row(OP_FREE, 63, 0, 0, 0, 1, mk(KIND_REPLY, 63, 0, 0, 0, 0, 0, 1));
      add_row(OP_INIT, 40, 0, 4'hF, 8'hFF, 1, mk(KIND_REPLY, 40, 0, 0, 0, 0, 0, 1));
      add_row(OP_SETTIME, 32, 5, 0, 0, 1, mk(KIND_REPLY, 32, 0, 0, 0, 0, 0, 1));
      add_row(OP_BAD5, 7, 1, 1, 1, 1, mk(KIND_REPLY, 0, 0, 0, 0, 0, 0, 1));
      add_row(OP_BAD6, 63, 32'hFFFF_FFFF, 4'hF, 8'hFF, 1, mk(KIND_REPLY, 0, 0, 0, 0, 0, 0, 1));
      add_row(OP_BAD7, 0, 0, 0, 0, 1, mk(KIND_REPLY, 0, 0, 0, 0, 0, 0, 1));
      add_row(OP_FREE, 0, 0, 0, 0, 0, nil);
      add_row(OP_SETTIME, 0, 2, 0, 0, 0, nil);             // settime starts a free entry
      add_row(OP_FREE, 2, 0, 0, 0, 0, nil);
      add_row(OP_TICK, 0, 0, 0, 0, 0, nil);
      add_row(OP_TICK, 0, 0, 0, 0, 0, nil);
      add_row(OP_ALLOC, 0, 0, 0, 0, 1, mk(KIND_REPLY, 2, 1, 0, 0, 0, 0, 1));
      foreach (rows[i]) begin
         typed_valid = rows[i].typed;
         typed_reply = rows[i].reply;
         send_word(rows[i].op, rows[i].idx, rows[i].tmo, rows[i].que, rows[i].dat);
      end
      typed_valid = 0;
      wait_idle();

      // random phases under different task timer settings
      task_ids[0] = '0;
      task_ids[1] = IDX_W'($urandom_range(0, NT - 1));
      task_ids[2] = IDX_W'(63);
      task_ids[3] = IDX_W'(NT - 1);
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(REG_TASK_EN, IDX_W'((ph == 0) ? 0 : 1));
         write_reg(REG_TASK_IDX, task_ids[ph]);
         for (int n = 0; n < 108; n++) begin
            if (n % 36 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_random();
         end
         no_idle = 0;
         wait_idle();
      end

      $display("%0d requests, %0d result words, %0d expiries, %0d switch requests",
               items_sent, words_seen, expiries_seen, switches_seen);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatching words", mismatches);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/stt_pkg.sv
src/stt_front.sv
src/stt_back.sv
src/software_timer_table.sv
dv/software_timer_table_tb.sv
